FILE: sv/cki_pkg.sv
`default_nettype none

package cki_pkg;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_FIND  = 2'd1,
      CMD_GET   = 2'd2,
      CMD_CLEAR = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_EXISTS    = 3'd3,
      ST_DUPLICATE = 3'd4
   } status_type;

   typedef struct packed {
      command_type command;
      logic [63:0] table_key;
      logic [63:0] column_key;
      logic [7:0]  position;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  found_position;
      logic [63:0] table_key_out;
      logic [63:0] column_key_out;
   } rsp_type;

   typedef enum logic [2:0] {
      HS_IDLE,
      HS_MIX,
      HS_FINAL,
      HS_MOD,
      HS_DONE
   } hash_state_type;

   typedef enum logic [3:0] {
      MS_CLEAR,
      MS_IDLE,
      MS_ADD_CELL,
      MS_HASH_START,
      MS_HASH_WAIT,
      MS_BKT_RD,
      MS_BKT_EVAL,
      MS_SCAN_RD,
      MS_SCAN_CMP,
      MS_GET_RD,
      MS_GET_DATA,
      MS_RESP
   } map_state_type;

   // Multiplier and initial value of the 32-bit mixing hash over 16 key bytes.
   localparam logic [31:0] HASH_M    = 32'h5bd1e995;
   localparam logic [31:0] HASH_INIT = 32'd16;

endpackage

`default_nettype wire

FILE: sv/cki_ram.sv
`default_nettype none

module cki_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/cki_hash.sv
`default_nettype none

module cki_hash
   import cki_pkg::*;
#(
   parameter int BUCKET_COUNT = 1024,
   localparam int IW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1,
   localparam int RW = $clog2(BUCKET_COUNT) + 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [63:0]   table_key,
   input  wire logic [63:0]   column_key,
   output logic               done,
   output logic [IW-1:0]      bucket
);

   // Reciprocal of the bucket count scaled by 2^32; the quotient estimate it
   // gives is never more than one below the true quotient.
   localparam logic [31:0] RECIP = (BUCKET_COUNT > 1)
                                   ? 32'((64'd1 << 32) / BUCKET_COUNT) : 32'hffff_ffff;

   hash_state_type state_ff, state_in;

   logic [63:0]   tk_ff, ck_ff;
   logic [31:0]   h_ff, k_ff, q_ff;
   logic [1:0]    word_ff, sub_ff;
   logic [4:0]    bit_ff;
   logic [RW-1:0] rem_ff;

   logic [31:0] word_sel, mul_a, prod;
   logic [63:0] wide_prod;
   logic [31:0] q_times_b;

   always_comb begin
      case (word_ff)
         2'd0:    word_sel = tk_ff[31:0];
         2'd1:    word_sel = tk_ff[63:32];
         2'd2:    word_sel = ck_ff[31:0];
         default: word_sel = ck_ff[63:32];
      endcase
   end

   // One multiplier is shared by the mixing and final steps; the reduction uses two more products.
   always_comb begin
      if (state_ff == HS_FINAL) begin
         mul_a = h_ff ^ (h_ff >> 13);
      end else begin
         case (sub_ff)
            2'd0:    mul_a = word_sel;
            2'd1:    mul_a = k_ff ^ (k_ff >> 24);
            default: mul_a = h_ff;
         endcase
      end
      prod      = mul_a * HASH_M;
      wide_prod = 64'(h_ff) * 64'(RECIP);
      q_times_b = q_ff * 32'(BUCKET_COUNT);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         HS_IDLE:  if (start) state_in = HS_MIX;
         HS_MIX:   if (sub_ff == 2'd2 && word_ff == 2'd3) state_in = HS_FINAL;
         HS_FINAL: state_in = HS_MOD;
         HS_MOD:   if (bit_ff == 5'd2) state_in = HS_DONE;
         HS_DONE:  state_in = HS_IDLE;
         default:  state_in = HS_IDLE;
      endcase
   end

   always_comb begin
      done   = (state_ff == HS_DONE);
      bucket = IW'(rem_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      case (state_ff)
         HS_IDLE: begin
            tk_ff   <= table_key;
            ck_ff   <= column_key;
            h_ff    <= HASH_INIT;
            word_ff <= 2'd0;
            sub_ff  <= 2'd0;
         end
         HS_MIX: begin
            if (sub_ff == 2'd2) begin
               h_ff    <= prod ^ k_ff;
               sub_ff  <= 2'd0;
               word_ff <= word_ff + 2'd1;
            end else begin
               k_ff   <= prod;
               sub_ff <= sub_ff + 2'd1;
            end
         end
         HS_FINAL: begin
            h_ff   <= prod ^ (prod >> 15);
            rem_ff <= '0;
            bit_ff <= '0;
         end
         HS_MOD: begin
            // Quotient estimate, partial remainder below twice the bucket
            // count, then one correcting subtraction.
            case (bit_ff)
               5'd0:    q_ff <= wide_prod[63:32];
               5'd1:    h_ff <= h_ff - q_times_b;
               default: begin
                  if (h_ff >= 32'(BUCKET_COUNT)) begin
                     rem_ff <= RW'(h_ff - 32'(BUCKET_COUNT));
                  end else begin
                     rem_ff <= RW'(h_ff);
                  end
               end
            endcase
            bit_ff <= bit_ff + 5'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/column_key_index_map.sv
`default_nettype none

// Maps a key pair (table key, column key) to a dense position and back. An
// add appends the pair at the next free position and places it in the bucket
// chosen by a 32-bit multiplicative hash of the 16 key bytes, or in a linear
// overflow area when that bucket is taken; find, get and clear work on the
// same stores. One item is worked on at a time. A get reads the store memory
// and then responds. An add and a find wait for the hash unit: 13 products
// through one shared multiplier and a three-step reduction by a reciprocal
// product, followed by one bucket memory read. An add that finds the map
// full, a find with a zero key part and a get beyond the count go straight
// to the response state. A find that misses in its bucket then walks the
// overflow area, reading and comparing one entry at a time through the
// store memory read port.
// After reset and on every clear the bucket memory is swept, one entry a
// cycle, and no transfer is accepted while the sweep runs.
// A finished result sits in an output register, so the next transfer can
// be accepted while it waits.
module column_key_index_map
   import cki_pkg::*;
#(
   parameter int MAX_ENTRIES  = 256,
   parameter int BUCKET_COUNT = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int PW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNTW = $clog2(MAX_ENTRIES + 1);
   localparam int IW   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int SAW  = $clog2(2 * MAX_ENTRIES);
   localparam int DW   = 128 + PW;

   map_state_type state_ff, state_in;

   req_type         cur_ff;
   rsp_type         res_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;
   logic [CNTW-1:0] cell_count_ff, spill_count_ff, scan_ff;
   logic [IW-1:0]   clr_ff;
   logic            clr_resp_ff;

   // Bucket memory holds {table key, column key, position}; the store memory
   // holds the cells in its lower half and the overflow area in its upper.
   logic            bkt_we, bkt_re, st_we, st_re;
   logic [IW-1:0]   bkt_waddr;
   logic [DW-1:0]   bkt_wdata, bkt_rdata;
   logic [SAW-1:0]  st_waddr, st_raddr;
   logic [DW-1:0]   st_wdata, st_rdata;

   logic            hash_start, hash_done;
   logic [IW-1:0]   hash_bucket;

   logic            accept, out_free, clr_last;
   logic            cell_full, spill_full;
   logic            bkt_empty, bkt_match, st_match, scan_last;
   logic [PW-1:0]   bkt_pos, st_pos;
   logic [63:0]     bkt_tk, bkt_ck, st_tk, st_ck;
   logic            get_ok;
   status_type      acc_status;

   cki_ram #(.WIDTH(DW), .DEPTH(BUCKET_COUNT)) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bkt_waddr),
      .wr_data (bkt_wdata),
      .rd_en   (bkt_re),
      .rd_addr (hash_bucket),
      .rd_data (bkt_rdata)
   );

   cki_ram #(.WIDTH(DW), .DEPTH(2 * MAX_ENTRIES)) u_store_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   cki_hash #(.BUCKET_COUNT(BUCKET_COUNT)) u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (hash_start),
      .table_key  (cur_ff.table_key),
      .column_key (cur_ff.column_key),
      .done       (hash_done),
      .bucket     (hash_bucket)
   );

   always_comb begin
      accept     = req_valid && req_ready;
      out_free   = !rsp_valid_ff || rsp_ready;
      clr_last   = (clr_ff == IW'(BUCKET_COUNT - 1));
      cell_full  = (cell_count_ff >= CNTW'(MAX_ENTRIES));
      spill_full = (spill_count_ff >= CNTW'(MAX_ENTRIES));
      get_ok     = (32'(req_data.position) < 32'(cell_count_ff));

      bkt_tk    = bkt_rdata[DW-1 -: 64];
      bkt_ck    = bkt_rdata[DW-65 -: 64];
      bkt_pos   = bkt_rdata[PW-1:0];
      // A bucket counts as empty when either stored key part is zero.
      bkt_empty = (bkt_tk == 64'd0) || (bkt_ck == 64'd0);
      bkt_match = (bkt_tk == cur_ff.table_key) && (bkt_ck == cur_ff.column_key);

      st_tk     = st_rdata[DW-1 -: 64];
      st_ck     = st_rdata[DW-65 -: 64];
      st_pos    = st_rdata[PW-1:0];
      st_match  = (st_tk == cur_ff.table_key) && (st_ck == cur_ff.column_key);
      scan_last = ((CNTW + 1)'(scan_ff) + (CNTW + 1)'(1))
                  >= (CNTW + 1)'(spill_count_ff);
   end

   // Status known at the moment a request is taken.
   always_comb begin
      acc_status = ST_OK;
      case (req_data.command)
         CMD_ADD: begin
            if (cell_full) acc_status = ST_FULL;
         end
         CMD_FIND: begin
            if (req_data.table_key == 64'd0 || req_data.column_key == 64'd0)
               acc_status = ST_NOT_FOUND;
         end
         CMD_GET: begin
            if (!get_ok) acc_status = ST_NOT_FOUND;
         end
         default: acc_status = ST_OK;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MS_CLEAR: begin
            if (clr_last) state_in = clr_resp_ff ? MS_RESP : MS_IDLE;
         end
         MS_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  CMD_ADD:   state_in = cell_full ? MS_RESP : MS_ADD_CELL;
                  CMD_FIND: begin
                     if (req_data.table_key == 64'd0 || req_data.column_key == 64'd0)
                        state_in = MS_RESP;
                     else
                        state_in = MS_HASH_START;
                  end
                  CMD_GET:   state_in = get_ok ? MS_GET_RD : MS_RESP;
                  CMD_CLEAR: state_in = MS_CLEAR;
                  default:   state_in = MS_RESP;
               endcase
            end
         end
         MS_ADD_CELL:   state_in = MS_HASH_START;
         MS_HASH_START: state_in = MS_HASH_WAIT;
         MS_HASH_WAIT:  if (hash_done) state_in = MS_BKT_RD;
         MS_BKT_RD:     state_in = MS_BKT_EVAL;
         MS_BKT_EVAL: begin
            if (cur_ff.command == CMD_FIND && !bkt_match && !bkt_empty
                && spill_count_ff != '0)
               state_in = MS_SCAN_RD;
            else
               state_in = MS_RESP;
         end
         MS_SCAN_RD:    state_in = MS_SCAN_CMP;
         MS_SCAN_CMP:   state_in = (st_match || scan_last) ? MS_RESP : MS_SCAN_RD;
         MS_GET_RD:     state_in = MS_GET_DATA;
         MS_GET_DATA:   state_in = MS_RESP;
         MS_RESP:       if (out_free) state_in = MS_IDLE;
         default:       state_in = MS_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == MS_IDLE);
      hash_start = (state_ff == MS_HASH_START);
      bkt_re     = (state_ff == MS_BKT_RD);
      bkt_we     = 1'b0;
      bkt_waddr  = hash_bucket;
      bkt_wdata  = {cur_ff.table_key, cur_ff.column_key, PW'(cell_count_ff)};
      st_we      = 1'b0;
      st_waddr   = SAW'(cell_count_ff);
      st_wdata   = {cur_ff.table_key, cur_ff.column_key, PW'(cell_count_ff)};
      st_re      = 1'b0;
      st_raddr   = SAW'(cur_ff.position);
      unique case (state_ff)
         MS_CLEAR: begin
            bkt_we    = 1'b1;
            bkt_waddr = clr_ff;
            bkt_wdata = '0;
         end
         MS_ADD_CELL: st_we = 1'b1;
         MS_BKT_EVAL: begin
            if (cur_ff.command == CMD_ADD) begin
               if (bkt_empty) begin
                  bkt_we = 1'b1;
               end else if (!bkt_match && !spill_full) begin
                  st_we    = 1'b1;
                  st_waddr = SAW'(MAX_ENTRIES) + SAW'(spill_count_ff);
               end
            end
         end
         MS_SCAN_RD: begin
            st_re    = 1'b1;
            st_raddr = SAW'(MAX_ENTRIES) + SAW'(scan_ff);
         end
         MS_GET_RD: st_re = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= MS_CLEAR;
         clr_ff         <= '0;
         clr_resp_ff    <= 1'b0;
         cell_count_ff  <= '0;
         spill_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            MS_CLEAR: begin
               clr_ff <= clr_last ? '0 : clr_ff + IW'(1);
               if (clr_last) begin
                  clr_resp_ff    <= 1'b0;
                  cell_count_ff  <= '0;
                  spill_count_ff <= '0;
               end
            end
            MS_IDLE: begin
               if (accept) begin
                  cur_ff <= req_data;
                  res_ff <= {acc_status, 8'd0, 64'd0, 64'd0};
                  if (req_data.command == CMD_CLEAR) clr_resp_ff <= 1'b1;
               end
            end
            MS_BKT_EVAL: begin
               if (cur_ff.command == CMD_ADD) begin
                  if (bkt_empty) begin
                     cell_count_ff <= cell_count_ff + CNTW'(1);
                  end else if (bkt_match) begin
                     res_ff.status <= (CNTW'(bkt_pos) == cell_count_ff)
                                      ? ST_EXISTS : ST_DUPLICATE;
                  end else if (spill_full) begin
                     res_ff.status <= ST_FULL;
                  end else begin
                     spill_count_ff <= spill_count_ff + CNTW'(1);
                     cell_count_ff  <= cell_count_ff + CNTW'(1);
                  end
               end else begin
                  scan_ff <= '0;
                  if (bkt_match) begin
                     if (CNTW'(bkt_pos) < cell_count_ff)
                        res_ff.found_position <= 8'(bkt_pos);
                     else
                        res_ff.status <= ST_NOT_FOUND;
                  end else if (bkt_empty || spill_count_ff == '0) begin
                     res_ff.status <= ST_NOT_FOUND;
                  end
               end
            end
            MS_SCAN_CMP: begin
               scan_ff <= scan_ff + CNTW'(1);
               if (st_match) begin
                  // The first matching overflow entry decides the answer.
                  if (CNTW'(st_pos) < cell_count_ff)
                     res_ff.found_position <= 8'(st_pos);
                  else
                     res_ff.status <= ST_NOT_FOUND;
               end else if (scan_last) begin
                  res_ff.status <= ST_NOT_FOUND;
               end
            end
            MS_GET_DATA: begin
               {res_ff.table_key_out, res_ff.column_key_out} <= {st_tk, st_ck};
            end
            MS_RESP: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

endmodule

`default_nettype wire

FILE: sv/cki_checker.sv
`default_nettype none

module cki_checker
   import cki_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // Reset starts the bucket sweep, so nothing is taken or shown just after.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("port active right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_DUPLICATE)
      else $error("status code out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.found_position == 8'd0 && rsp_data.table_key_out == 64'd0
         && rsp_data.column_key_out == 64'd0)
      else $error("failed result carries data");

   // An accepted request yields no result in the very next cycle.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared without processing");

endmodule

bind column_key_index_map cki_checker u_cki_checker (.*);

`default_nettype wire
